### sv/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the CSV stream tokenizer
// Request payload types, parser state record, byte classes, state codes,
// status codes and the parser transition table.
// ----------------------------------------------------------------------------
package cst_pkg;

  // counter widths
  localparam int ROW_BITS   = 24;
  localparam int FIELD_BITS = 16;

  // byte characters
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_QUOTE = 8'h22;

  // byte classes
  localparam logic [2:0] CLS_NL    = 3'd0;
  localparam logic [2:0] CLS_COMMA = 3'd1;
  localparam logic [2:0] CLS_QUOTE = 3'd2;
  localparam logic [2:0] CLS_OTHER = 3'd3;
  localparam logic [2:0] CLS_END   = 3'd4;

  // parser states
  localparam logic [2:0] PS_START  = 3'd0;
  localparam logic [2:0] PS_UNQ    = 3'd1;
  localparam logic [2:0] PS_OPENQ  = 3'd2;
  localparam logic [2:0] PS_INQ    = 3'd3;
  localparam logic [2:0] PS_QAFTER = 3'd4;
  localparam logic [2:0] PS_COMMA  = 3'd5;
  localparam logic [2:0] PS_NL     = 3'd6;

  // transition results beyond the stored states
  localparam logic [3:0] NX_END = 4'd7;
  localparam logic [3:0] NX_ERR = 4'd8;

  // status codes
  localparam logic [1:0] STAT_RUN      = 2'd0;
  localparam logic [1:0] STAT_OK       = 2'd1;
  localparam logic [1:0] STAT_SYNTAX   = 2'd2;
  localparam logic [1:0] STAT_MISMATCH = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic                  content_valid;
    logic [7:0]            content_byte;
    logic                  field_end;
    logic                  record_end;
    logic                  done_res;
    logic [1:0]            status;
    logic [ROW_BITS-1:0]   row_count;
    logic [FIELD_BITS-1:0] column_count;
    logic [ROW_BITS-1:0]   line_number;
    logic [FIELD_BITS-1:0] column_number;
  } out_item_t;

  // parser state; parse_state holds the error code while halted
  typedef struct packed {
    logic [2:0]            parse_state;
    logic [FIELD_BITS-1:0] first_field_count;
    logic [FIELD_BITS-1:0] field_counter;
    logic [ROW_BITS-1:0]   rows_seen;
    logic [ROW_BITS-1:0]   line_counter;
    logic [FIELD_BITS-1:0] column_counter;
    logic                  halted;
  } cst_state_t;

  localparam cst_state_t STATE_RESET = '{
    parse_state:       PS_START,
    first_field_count: '0,
    field_counter:     '0,
    rows_seen:         '0,
    line_counter:      ROW_BITS'(1),
    column_counter:    FIELD_BITS'(1),
    halted:            1'b0
  };

  // transition table: state x byte class
  function automatic logic [3:0] next_state(input logic [2:0] prev, input logic [2:0] cls);
    logic [3:0] nxt;
    case (prev)
      PS_UNQ: begin
        case (cls)
          CLS_NL:    nxt = 4'(PS_NL);
          CLS_COMMA: nxt = 4'(PS_COMMA);
          CLS_QUOTE: nxt = 4'(PS_UNQ);
          CLS_OTHER: nxt = 4'(PS_UNQ);
          default:   nxt = NX_END;
        endcase
      end
      PS_OPENQ,
      PS_INQ: begin
        case (cls)
          CLS_NL:    nxt = 4'(PS_INQ);
          CLS_COMMA: nxt = 4'(PS_INQ);
          CLS_QUOTE: nxt = 4'(PS_QAFTER);
          CLS_OTHER: nxt = 4'(PS_INQ);
          default:   nxt = NX_ERR;
        endcase
      end
      PS_QAFTER: begin
        case (cls)
          CLS_NL:    nxt = 4'(PS_NL);
          CLS_COMMA: nxt = 4'(PS_COMMA);
          CLS_QUOTE: nxt = 4'(PS_INQ);
          CLS_OTHER: nxt = NX_ERR;
          default:   nxt = NX_END;
        endcase
      end
      default: begin
        case (cls)
          CLS_NL:    nxt = 4'(PS_NL);
          CLS_COMMA: nxt = 4'(PS_COMMA);
          CLS_QUOTE: nxt = 4'(PS_OPENQ);
          CLS_OTHER: nxt = 4'(PS_UNQ);
          default:   nxt = NX_END;
        endcase
      end
    endcase
    return nxt;
  endfunction

endpackage

### sv/cst_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_step: one-byte parser step
// Classifies the byte, walks the transition table, updates counters and
// builds the result for the request, all in one combinational pass.
// ----------------------------------------------------------------------------
module cst_step (
  input  cst_pkg::cst_state_t st_i,
  input  cst_pkg::in_item_t   item_i,
  output cst_pkg::cst_state_t st_nxt,
  output cst_pkg::out_item_t  res_o
);

  logic                           is_end;
  logic [2:0]                     cls;
  logic [2:0]                     prev;
  logic [3:0]                     nxt;
  logic                           fe;
  logic                           re;
  logic                           cv;
  logic                           mismatch;
  logic [cst_pkg::FIELD_BITS-1:0] fc_inc;
  logic [cst_pkg::ROW_BITS-1:0]   rows_inc;
  logic [cst_pkg::FIELD_BITS-1:0] ffc_new;
  logic [cst_pkg::ROW_BITS-1:0]   line_new;
  logic [cst_pkg::FIELD_BITS-1:0] col_new;

  // byte class
  always_comb begin
    is_end = item_i.end_marker || (item_i.ch == cst_pkg::CHR_NUL);
    if (is_end) begin
      cls = cst_pkg::CLS_END;
    end else if (item_i.ch == cst_pkg::CHR_NL) begin
      cls = cst_pkg::CLS_NL;
    end else if (item_i.ch == cst_pkg::CHR_COMMA) begin
      cls = cst_pkg::CLS_COMMA;
    end else if (item_i.ch == cst_pkg::CHR_QUOTE) begin
      cls = cst_pkg::CLS_QUOTE;
    end else begin
      cls = cst_pkg::CLS_OTHER;
    end
  end

  // table step and field / record marks
  always_comb begin
    prev = (st_i.parse_state > cst_pkg::PS_NL) ? cst_pkg::PS_START : st_i.parse_state;
    nxt  = cst_pkg::next_state(prev, cls);
    if (cls == cst_pkg::CLS_NL || cls == cst_pkg::CLS_COMMA) begin
      fe = prev inside {cst_pkg::PS_START, cst_pkg::PS_UNQ, cst_pkg::PS_QAFTER,
                        cst_pkg::PS_COMMA, cst_pkg::PS_NL};
    end else if (cls == cst_pkg::CLS_END) begin
      fe = prev inside {cst_pkg::PS_UNQ, cst_pkg::PS_QAFTER, cst_pkg::PS_COMMA};
    end else begin
      fe = 1'b0;
    end
    re = (nxt == 4'(cst_pkg::PS_NL)) ||
         (nxt == cst_pkg::NX_END && prev != cst_pkg::PS_START && prev != cst_pkg::PS_NL);
    cv = (nxt == 4'(cst_pkg::PS_UNQ)) || (nxt == 4'(cst_pkg::PS_INQ));
  end

  // saturating counters
  always_comb begin
    fc_inc = st_i.field_counter;
    if (fe && st_i.field_counter != '1) begin
      fc_inc = st_i.field_counter + 1'b1;
    end
    rows_inc = st_i.rows_seen;
    if (re && st_i.rows_seen != '1) begin
      rows_inc = st_i.rows_seen + 1'b1;
    end
    mismatch = re && (st_i.first_field_count != '0) && (st_i.first_field_count != fc_inc);
    ffc_new  = (re && st_i.first_field_count == '0) ? fc_inc : st_i.first_field_count;
    line_new = st_i.line_counter;
    col_new  = st_i.column_counter;
    if (nxt == 4'(cst_pkg::PS_NL)) begin
      line_new = (st_i.line_counter != '1) ? st_i.line_counter + 1'b1 : st_i.line_counter;
      col_new  = cst_pkg::FIELD_BITS'(1);
    end else if (nxt >= 4'(cst_pkg::PS_UNQ) && nxt <= 4'(cst_pkg::PS_COMMA)) begin
      col_new = (st_i.column_counter != '1) ? st_i.column_counter + 1'b1 : st_i.column_counter;
    end
  end

  // result and next state
  always_comb begin
    st_nxt              = st_i;
    res_o.content_valid = 1'b0;
    res_o.content_byte  = '0;
    res_o.field_end     = 1'b0;
    res_o.record_end    = 1'b0;
    res_o.done_res      = 1'b0;
    res_o.status        = cst_pkg::STAT_RUN;
    res_o.row_count     = st_i.rows_seen;
    res_o.column_count  = st_i.first_field_count;
    res_o.line_number   = st_i.line_counter;
    res_o.column_number = st_i.column_counter;

    if (st_i.halted) begin
      // drop bytes until the end request
      res_o.done_res = is_end;
      res_o.status   = (st_i.parse_state == 3'(cst_pkg::STAT_MISMATCH)) ?
                       cst_pkg::STAT_MISMATCH : cst_pkg::STAT_SYNTAX;
      if (is_end) begin
        st_nxt = cst_pkg::STATE_RESET;
      end
    end else if (nxt == cst_pkg::NX_ERR) begin
      // syntax error, counters keep the offending position
      res_o.done_res = 1'b1;
      res_o.status   = cst_pkg::STAT_SYNTAX;
      if (is_end) begin
        st_nxt = cst_pkg::STATE_RESET;
      end else begin
        st_nxt.halted      = 1'b1;
        st_nxt.parse_state = 3'(cst_pkg::STAT_SYNTAX);
      end
    end else if (mismatch) begin
      // field count mismatch, record already counted
      res_o.done_res  = 1'b1;
      res_o.status    = cst_pkg::STAT_MISMATCH;
      res_o.row_count = rows_inc;
      if (is_end) begin
        st_nxt = cst_pkg::STATE_RESET;
      end else begin
        st_nxt.halted        = 1'b1;
        st_nxt.parse_state   = 3'(cst_pkg::STAT_MISMATCH);
        st_nxt.rows_seen     = rows_inc;
        st_nxt.field_counter = fc_inc;
      end
    end else begin
      res_o.content_valid = cv;
      res_o.content_byte  = cv ? item_i.ch : 8'h00;
      res_o.field_end     = fe;
      res_o.record_end    = re;
      res_o.done_res      = is_end;
      res_o.status        = is_end ? cst_pkg::STAT_OK : cst_pkg::STAT_RUN;
      res_o.row_count     = rows_inc;
      res_o.column_count  = ffc_new;
      res_o.line_number   = line_new;
      res_o.column_number = col_new;
      if (is_end) begin
        st_nxt = cst_pkg::STATE_RESET;
      end else begin
        st_nxt.parse_state       = nxt[2:0];
        st_nxt.first_field_count = ffc_new;
        st_nxt.field_counter     = re ? '0 : fc_inc;
        st_nxt.rows_seen         = rows_inc;
        st_nxt.line_counter      = line_new;
        st_nxt.column_counter    = col_new;
      end
    end
  end

endmodule

### sv/csv_stream_tokenizer.sv
`timescale 1ns / 1ps
// Path: an accepted request passes the input register, then the result
// register, onto out_data; out_ready holding the result back delays it.
// Throughput: one byte per cycle while out_ready does not stall the result
// register; the parser step is combinational.
// Reset: synchronous active-low rst_n empties both registers and returns the
// parser to start of document, line 1, column 1, all counts zero.
// ----------------------------------------------------------------------------
// csv_stream_tokenizer: streaming CSV tokenizer with quoted fields
// Input register, one-pass parser step and result register with
// valid/ready on both sides.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cst_pkg::out_item_t out_data
);

  logic                s1_valid_r;
  cst_pkg::in_item_t   s1_item_r;
  cst_pkg::cst_state_t state_r;
  cst_pkg::cst_state_t state_nxt;
  cst_pkg::out_item_t  res;
  logic                out_valid_r;
  cst_pkg::out_item_t  out_item_r;
  logic                advance;

  // handshake
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // parser step
  cst_step u_step (
    .st_i   (state_r),
    .item_i (s1_item_r),
    .st_nxt (state_nxt),
    .res_o  (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

### sv/cst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker: port-level checks of the CSV stream tokenizer
// Watches the result channel for handshake and result consistency.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input cst_pkg::out_item_t out_data
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no content or marks on an error status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == cst_pkg::STAT_SYNTAX ||
                  out_data.status == cst_pkg::STAT_MISMATCH)
    |-> !out_data.content_valid && !out_data.field_end && !out_data.record_end)
    else $error("marks on error result");

  // a record end always closes a field
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_end |-> out_data.field_end)
    else $error("record end without field end");

  // content byte is zero unless valid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.content_valid |-> out_data.content_byte == 8'h00)
    else $error("stray content byte");

  // positions never drop to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_number != '0 && out_data.column_number != '0)
    else $error("position counter at zero");

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/csv_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_stream_checker: scoreboard for the CSV stream tokenizer
// Watches both channels, runs its own tokenizer state machine on every
// accepted request, queues the predicted token results and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module csv_stream_checker
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_results
);

  cst_state_t tok;
  out_item_t  expected_tokens[$];
  int         fails = 0;

  // where the parser goes from state st on a byte of class cls
  function automatic logic [3:0] target_state(input logic [2:0] st, input logic [2:0] cls);
    logic quoted;
    quoted = (st == PS_OPENQ) || (st == PS_INQ);
    case (cls)
      CLS_NL:    return quoted ? 4'(PS_INQ) : 4'(PS_NL);
      CLS_COMMA: return quoted ? 4'(PS_INQ) : 4'(PS_COMMA);
      CLS_QUOTE: begin
        if (quoted) return 4'(PS_QAFTER);
        if (st == PS_QAFTER) return 4'(PS_INQ);
        if (st == PS_UNQ) return 4'(PS_UNQ);
        return 4'(PS_OPENQ);
      end
      CLS_OTHER: begin
        if (quoted) return 4'(PS_INQ);
        if (st == PS_QAFTER) return NX_ERR;
        return 4'(PS_UNQ);
      end
      default:   return quoted ? NX_ERR : NX_END;
    endcase
  endfunction

  // one byte through the tokenizer: updates tok, returns the token result
  function automatic out_item_t tokenize(input in_item_t req);
    out_item_t   res;
    logic        is_end;
    logic [2:0]  cls;
    logic [2:0]  prev;
    logic [3:0]  nxt;
    logic        fe;
    logic        re;
    logic        cv;
    logic [1:0]  err;
    res = '0;
    err = STAT_RUN;
    is_end = req.end_marker || (req.ch == CHR_NUL);
    if (tok.halted) begin
      // dropping bytes after an error, status sticks
      res.done_res = is_end;
      res.status = (tok.parse_state == 3'(STAT_MISMATCH)) ? STAT_MISMATCH : STAT_SYNTAX;
    end else begin
      if (is_end) cls = CLS_END;
      else if (req.ch == CHR_NL) cls = CLS_NL;
      else if (req.ch == CHR_COMMA) cls = CLS_COMMA;
      else if (req.ch == CHR_QUOTE) cls = CLS_QUOTE;
      else cls = CLS_OTHER;
      prev = tok.parse_state;
      nxt = target_state(prev, cls);
      if (nxt == NX_ERR) begin
        err = STAT_SYNTAX;
      end else begin
        // empty fields still close, end right after newline closes nothing
        fe = ((cls == CLS_NL || cls == CLS_COMMA) && prev != PS_OPENQ && prev != PS_INQ) ||
             (cls == CLS_END && (prev == PS_UNQ || prev == PS_QAFTER || prev == PS_COMMA));
        re = (nxt == 4'(PS_NL)) || (nxt == NX_END && prev != PS_START && prev != PS_NL);
        if (fe && tok.field_counter != '1) tok.field_counter = tok.field_counter + 1'b1;
        if (re) begin
          if (tok.rows_seen != '1) tok.rows_seen = tok.rows_seen + 1'b1;
          if (tok.first_field_count == '0) tok.first_field_count = tok.field_counter;
          else if (tok.first_field_count != tok.field_counter) err = STAT_MISMATCH;
          if (err == STAT_RUN) tok.field_counter = '0;
        end
        if (err == STAT_RUN) begin
          // position of the next byte
          if (nxt == 4'(PS_NL)) begin
            if (tok.line_counter != '1) tok.line_counter = tok.line_counter + 1'b1;
            tok.column_counter = FIELD_BITS'(1);
          end else if (nxt >= 4'(PS_UNQ) && nxt <= 4'(PS_COMMA)) begin
            if (tok.column_counter != '1) tok.column_counter = tok.column_counter + 1'b1;
          end
          tok.parse_state = nxt[2:0];
          cv = (nxt == 4'(PS_UNQ)) || (nxt == 4'(PS_INQ));
          res.content_valid = cv;
          res.content_byte = cv ? req.ch : 8'h00;
          res.field_end = fe;
          res.record_end = re;
          res.done_res = is_end;
          res.status = is_end ? STAT_OK : STAT_RUN;
        end
      end
      if (err != STAT_RUN) begin
        res.done_res = 1'b1;
        res.status = err;
      end
    end
    res.row_count = tok.rows_seen;
    res.column_count = tok.first_field_count;
    res.line_number = tok.line_counter;
    res.column_number = tok.column_counter;
    // end item starts a fresh document, an error halts the parser
    if (is_end) begin
      tok = STATE_RESET;
    end else if (err != STAT_RUN) begin
      tok.halted = 1'b1;
      tok.parse_state = 3'(err);
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      tok = STATE_RESET;
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) expected_tokens.push_back(tokenize(in_data));
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          fails++;
          $display("%0t ns: result with no request waiting, expected none actual %h",
                   $time, out_data);
        end else begin
          want = expected_tokens.pop_front();
          check_field("content_valid", 32'(want.content_valid),
                      32'(out_data.content_valid));
          check_field("content_byte", 32'(want.content_byte), 32'(out_data.content_byte));
          check_field("field_end", 32'(want.field_end), 32'(out_data.field_end));
          check_field("record_end", 32'(want.record_end), 32'(out_data.record_end));
          check_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("row_count", 32'(want.row_count), 32'(out_data.row_count));
          check_field("column_count", 32'(want.column_count), 32'(out_data.column_count));
          check_field("line_number", 32'(want.line_number), 32'(out_data.line_number));
          check_field("column_number", 32'(want.column_number),
                      32'(out_data.column_number));
        end
      end
    end
    fail_count <= fails;
    pending_results <= expected_tokens.size();
  end

endmodule

### tb/csv_stream_tokenizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_test: top level test of the CSV stream tokenizer
// Drives directed documents for quoting, empty fields, blank lines, end
// handling and both error kinds, then random CSV documents with noise,
// under changing sender idle and receiver stall rates. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_test;
  import cst_pkg::*;

  localparam int RANDOM_ITEMS   = 500;
  localparam int PHASE_ITEMS    = 125;
  localparam int WATCHDOG_LIMIT = 1000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_results;

  int        send_idle = 0;
  int        recv_stall = 0;
  int        items_sent = 0;
  int        quiet_cycles = 0;
  logic [7:0] doc_bytes[$];

  csv_stream_tokenizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  csv_stream_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_item(input logic [7:0] data_byte, input logic end_flag);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= in_item_t'{ch: data_byte, end_marker: end_flag};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // hold off the sender until every predicted result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CHR_NL || b == CHR_COMMA || b == CHR_QUOTE);
    return b;
  endfunction

  // empty, unquoted, quoted with any bytes, quoted with delimiters
  task automatic add_field();
    int         kind;
    int         n;
    logic [7:0] b;
    kind = $urandom_range(0, 3);
    n = $urandom_range(1, 4);
    case (kind)
      0: ;
      1: repeat (n) doc_bytes.push_back(plain_byte());
      default: begin
        doc_bytes.push_back(CHR_QUOTE);
        repeat (n - 1) begin
          if (kind == 2) begin
            b = 8'($urandom_range(1, 255));
          end else begin
            case ($urandom_range(0, 3))
              0: b = CHR_COMMA;
              1: b = CHR_NL;
              2: b = CHR_QUOTE;
              default: b = plain_byte();
            endcase
          end
          doc_bytes.push_back(b);
          if (b == CHR_QUOTE) doc_bytes.push_back(CHR_QUOTE);
        end
        doc_bytes.push_back(CHR_QUOTE);
      end
    endcase
  endtask

  // mostly well-formed documents, some with bad field counts, stray
  // bytes, truncation or pure byte noise
  task automatic send_doc();
    int flavor;
    int ncol;
    int nrow;
    int cols;
    int keep;
    doc_bytes.delete();
    flavor = $urandom_range(0, 99);
    ncol = $urandom_range(1, 4);
    nrow = $urandom_range(1, 4);
    if (flavor < 6) begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 4))
          0: doc_bytes.push_back(CHR_NL);
          1: doc_bytes.push_back(CHR_COMMA);
          2: doc_bytes.push_back(CHR_QUOTE);
          default: doc_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      for (int r = 0; r < nrow; r++) begin
        cols = ncol;
        if (flavor < 14 && r > 0 && $urandom_range(0, 1) == 1)
          cols = (ncol > 1 && $urandom_range(0, 1) == 1) ? ncol - 1 : ncol + 1;
        for (int c = 0; c < cols; c++) begin
          if (c > 0) doc_bytes.push_back(CHR_COMMA);
          add_field();
        end
        if (r < nrow - 1 || $urandom_range(0, 1) == 1) doc_bytes.push_back(CHR_NL);
      end
      if (flavor >= 14 && flavor < 22) begin
        doc_bytes.insert($urandom_range(0, doc_bytes.size()), 8'($urandom_range(0, 255)));
      end else if (flavor >= 22 && flavor < 28 && doc_bytes.size() > 1) begin
        keep = $urandom_range(1, doc_bytes.size() - 1);
        while (doc_bytes.size() > keep) void'(doc_bytes.pop_back());
      end
    end
    foreach (doc_bytes[i]) send_item(doc_bytes[i], 1'b0);
    if ($urandom_range(0, 1) == 1) send_item(8'($urandom_range(0, 255)), 1'b1);
    else send_item(CHR_NUL, 1'b0);
  endtask

  initial begin
    int directed_items;
    int phase;
    int cur_phase;
    cur_phase = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty document, end flag with a newline byte that must be ignored
    send_item(CHR_NL, 1'b1);
    // doubled quote, empty field, extreme bytes, blank line as a
    // one-field record giving a count mismatch, dropped bytes, NUL end
    send_text("\"a\"\"\",\n");
    send_item(8'hFF, 1'b0);
    send_item(8'h01, 1'b0);
    send_text(",\n");
    send_text("\n");
    send_text("x");
    send_item(CHR_NUL, 1'b0);
    // end right after newline
    send_text("a\n");
    send_item(8'h7F, 1'b1);
    // stray byte after closing quote, then end
    send_text("\"q\"x");
    send_item(8'h78, 1'b1);
    // end inside an open quoted field
    send_text("\"ab");
    send_item(CHR_NUL, 1'b0);
    directed_items = items_sent;

    // random documents over the idle phases
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      phase = (items_sent - directed_items) / PHASE_ITEMS;
      if (phase > 3) phase = 3;
      if (phase != cur_phase) begin
        wait_drained();
        case (phase)
          1: begin
            send_idle = 59;
            recv_stall = 0;
          end
          2: begin
            send_idle = 0;
            recv_stall = 59;
          end
          default: begin
            send_idle = 36;
            recv_stall = 36;
          end
        endcase
        cur_phase = phase;
      end
      send_doc();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/cst_pkg.sv
sv/cst_step.sv
sv/csv_stream_tokenizer.sv
sv/cst_checker.sv
tb/csv_stream_checker.sv
tb/csv_stream_tokenizer_test.sv
